// File: design/sorted_order_priority_queue_core_defines.svh
// assertion macros for the sorted order queue
`ifndef SORTED_ORDER_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_ORDER_PRIORITY_QUEUE_CORE_DEFINES_SVH

`define SOPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define SOPQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/sopq_pkg.sv
package sopq_pkg;

	localparam int CapacityDef = 64;

	localparam logic [2:0] StOk       = 3'd0;
	localparam logic [2:0] StFull     = 3'd1;
	localparam logic [2:0] StEmpty    = 3'd2;
	localparam logic [2:0] StNotFound = 3'd3;
	localparam logic [2:0] StBadIndex = 3'd4;

	localparam logic [1:0] ReqPush  = 2'd0;
	localparam logic [1:0] ReqPop   = 2'd1;
	localparam logic [1:0] ReqFind  = 2'd2;
	localparam logic [1:0] ReqErase = 2'd3;

	typedef struct packed {
		logic [31:0] price;
		logic [30:0] quantity;
		logic        sell;
		logic        buy;
		logic [7:0]  kind;
		logic [15:0] trader;
		logic [30:0] order_id;
		logic [31:0] stamp;
	} entry_t;

	typedef struct packed {
		logic [1:0] req_type;
		entry_t     ent;
		logic [5:0] position;
	} req_t;

endpackage

// File: design/sopq_mem.sv
module sopq_mem #(
	parameter int Depth = sopq_pkg::CapacityDef,
	parameter int AddrW = $clog2(Depth)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AddrW-1:0]     waddr,
	input  sopq_pkg::entry_t     wdata,
	input  logic [AddrW-1:0]     raddr,
	output sopq_pkg::entry_t     rdata
);
	import sopq_pkg::*;

	entry_t mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/sorted_order_priority_queue_core.sv
// Sorted order queue: up to CAPACITY orders kept in one memory with a
// registered read, sorted by stamp with the highest first; a push goes behind
// entries of equal stamp. One request is in flight at a time. A find scans
// from the head. A pop or erase shifts the tail down one place. A push scans
// for its slot and shifts the tail up. A rejected request skips the scan and
// the shift and goes straight to the output state. The head entry is
// mirrored in a register. The result waits in an output register; the next
// request can be taken in the cycle after the result is handed over.
module sorted_order_priority_queue_core #(
	parameter int CAPACITY = sopq_pkg::CapacityDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// req_type, stamp, order_id, trader_code, order_kind, buy_flag, sell_flag,
	// quantity, price, position (160 bits)
	input  logic [159:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status, found_index, entry_count, head_valid, head_stamp, head_order_id,
	// head_trader, head_kind, head_buy, head_sell, head_quantity, head_price
	// (169 bits) + zero pad
	output logic [175:0] m_tdata
);
	import sopq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_SHUP, S_SHDN, S_HEAD, S_OUT
	} state_t;

	state_t      state_q;
	req_t        req_q;
	logic [CW-1:0] cnt_q, idx_q, slot_q;
	logic        found_q;
	logic [2:0]  status_q;
	entry_t      head_q;
	logic        rd_pend_q;

	logic        we;
	logic [AW-1:0] waddr, raddr;
	entry_t      wdata, rdata;

	req_t in_req;
	assign in_req.req_type      = s_tdata[1:0];
	assign in_req.ent.stamp     = s_tdata[33:2];
	assign in_req.ent.order_id  = s_tdata[64:34];
	assign in_req.ent.trader    = s_tdata[80:65];
	assign in_req.ent.kind      = s_tdata[88:81];
	assign in_req.ent.buy       = s_tdata[89];
	assign in_req.ent.sell      = s_tdata[90];
	assign in_req.ent.quantity  = s_tdata[121:91];
	assign in_req.ent.price     = s_tdata[153:122];
	assign in_req.position      = s_tdata[159:154];

	sopq_mem #(.Depth(CAPACITY), .AddrW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign s_tready = (state_q == S_IDLE);

	// scan reads idx_q; rdata is registered and holds entry idx_q-1 in the next cycle
	// shift up: read idx_q-1, write idx_q next cycle; shift down: read idx_q+1, write idx_q
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata;
		raddr = idx_q[AW-1:0];
		case (state_q)
			S_SHUP: begin
				raddr = idx_q[AW-1:0] - AW'(1);
				if (rd_pend_q) begin
					we    = 1'b1;
					waddr = idx_q[AW-1:0];
				end
				if (idx_q == slot_q) begin
					we    = 1'b1;
					wdata = req_q.ent;
				end
			end
			S_SHDN: begin
				raddr = idx_q[AW-1:0] + AW'(1);
				we    = rd_pend_q;
				waddr = idx_q[AW-1:0];
			end
			S_HEAD: raddr = '0;
			default: raddr = idx_q[AW-1:0];
		endcase
	end

	logic [CW-1:0] idx_m1;
	assign idx_m1 = idx_q - CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			m_tvalid  <= 1'b0;
			rd_pend_q <= 1'b0;
			idx_q     <= '0;
			slot_q    <= '0;
			found_q   <= 1'b0;
			status_q  <= StOk;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						req_q     <= in_req;
						idx_q     <= '0;
						rd_pend_q <= 1'b0;
						found_q   <= 1'b0;
						status_q  <= StOk;
						slot_q    <= '0;
						case (in_req.req_type)
							ReqPush: begin
								if (cnt_q == CW'(CAPACITY)) begin
									status_q <= StFull;
									state_q  <= S_OUT;
								end else begin
									state_q <= S_SCAN;
								end
							end
							ReqPop: begin
								if (cnt_q == '0) begin
									status_q <= StEmpty;
									state_q  <= S_OUT;
								end else begin
									state_q <= S_SHDN;
								end
							end
							ReqFind: state_q <= S_SCAN;
							default: begin
								if (CW'(in_req.position) >= cnt_q ||
									32'(in_req.position) >= CAPACITY) begin
									status_q <= StBadIndex;
									state_q  <= S_OUT;
								end else begin
									idx_q   <= CW'(in_req.position);
									state_q <= S_SHDN;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					// rdata holds entry idx_q-1 when rd_pend_q
					if (rd_pend_q && req_q.req_type == ReqPush &&
						rdata.stamp < req_q.ent.stamp) begin
						slot_q    <= idx_m1;
						idx_q     <= cnt_q;
						rd_pend_q <= 1'b0;
						state_q   <= S_SHUP;
					end else if (rd_pend_q && req_q.req_type == ReqFind &&
						rdata.stamp == req_q.ent.stamp &&
						rdata.order_id == req_q.ent.order_id) begin
						slot_q  <= idx_m1;
						found_q <= 1'b1;
						state_q <= S_OUT;
					end else if (idx_q == cnt_q) begin
						if (req_q.req_type == ReqPush) begin
							slot_q    <= cnt_q;
							idx_q     <= cnt_q;
							rd_pend_q <= 1'b0;
							state_q   <= S_SHUP;
						end else begin
							status_q <= StNotFound;
							state_q  <= S_OUT;
						end
					end else begin
						idx_q     <= idx_q + CW'(1);
						rd_pend_q <= 1'b1;
					end
				end
				S_SHUP: begin
					if (idx_q == slot_q) begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_HEAD;
					end else if (!rd_pend_q) begin
						rd_pend_q <= 1'b1;
					end else begin
						idx_q     <= idx_m1;
						rd_pend_q <= 1'b0;
					end
				end
				S_SHDN: begin
					if (idx_q + CW'(1) >= cnt_q) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_HEAD;
					end else if (!rd_pend_q) begin
						rd_pend_q <= 1'b1;
					end else begin
						idx_q     <= idx_q + CW'(1);
						rd_pend_q <= 1'b0;
					end
				end
				S_HEAD: begin
					if (rd_pend_q) begin
						head_q  <= rdata;
						state_q <= S_OUT;
					end else begin
						rd_pend_q <= 1'b1;
					end
				end
				S_OUT: begin
					if (!m_tvalid) begin
						m_tvalid <= 1'b1;
					end else if (m_tready) begin
						m_tvalid <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic hv;
	assign hv = (cnt_q != '0);

	always_comb begin
		m_tdata          = '0;
		m_tdata[2:0]     = status_q;
		m_tdata[8:3]     = found_q ? 6'(slot_q) : 6'd0;
		m_tdata[15:9]    = 7'(cnt_q);
		m_tdata[16]      = hv;
		if (hv) begin
			m_tdata[48:17]   = head_q.stamp;
			m_tdata[79:49]   = head_q.order_id;
			m_tdata[95:80]   = head_q.trader;
			m_tdata[103:96]  = head_q.kind;
			m_tdata[104]     = head_q.buy;
			m_tdata[105]     = head_q.sell;
			m_tdata[136:106] = head_q.quantity;
			m_tdata[168:137] = head_q.price;
		end
	end

endmodule

// File: design/sopq_checker.sv
module sopq_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [175:0] m_tdata
);
	`include "sorted_order_priority_queue_core_defines.svh"

	`SOPQ_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped while stalled")
	`SOPQ_ASSERT_IMP(a_excl, clk, arst_n, m_tvalid, !s_tready, "request taken while result pending")
	`SOPQ_ASSERT_IMP(a_head, clk, arst_n, m_tvalid, m_tdata[16] == (m_tdata[15:9] != 7'd0), "head valid mismatch")
	`SOPQ_ASSERT_IMP(a_cnt, clk, arst_n, m_tvalid, m_tdata[15:9] <= 7'd64, "count beyond capacity")

endmodule

bind sorted_order_priority_queue_core sopq_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import sopq_pkg::*;

	localparam int Cap = CapacityDef;

	typedef struct {
		logic [1:0]  req;
		logic [31:0] stamp;
		logic [30:0] oid;
		logic [15:0] trader;
		logic [7:0]  kind;
		logic        buy;
		logic        sell;
		logic [30:0] qty;
		logic [31:0] price;
		logic [5:0]  pos;
	} order_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  found;
		logic [6:0]  count;
		logic        hvalid;
		logic [31:0] hstamp;
		logic [30:0] hoid;
		logic [15:0] htrader;
		logic [7:0]  hkind;
		logic        hbuy;
		logic        hsell;
		logic [30:0] hqty;
		logic [31:0] hprice;
	} queue_resp_t;

	typedef struct {
		order_req_t  r;
		logic        has_exp;
		queue_resp_t exp;
	} dir_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [159:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [175:0] m_tdata;

	sorted_order_priority_queue_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	order_req_t  book[$];
	queue_resp_t pending_resp[$];
	queue_resp_t typed_resp[$];
	bit          typed_flag[$];
	int          errors;
	int          resp_seen;
	int          finds_hit;
	int          fulls;
	bit          quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("sorted_order_priority_queue_core regression: fail");
		$finish;
	end

	function automatic logic [159:0] pack_req(order_req_t r);
		return {r.pos, r.price, r.qty, r.sell, r.buy, r.kind, r.trader, r.oid,
			r.stamp, r.req};
	endfunction

	function automatic queue_resp_t unpack_resp(logic [175:0] d);
		queue_resp_t q;
		q.status  = d[2:0];
		q.found   = d[8:3];
		q.count   = d[15:9];
		q.hvalid  = d[16];
		q.hstamp  = d[48:17];
		q.hoid    = d[79:49];
		q.htrader = d[95:80];
		q.hkind   = d[103:96];
		q.hbuy    = d[104];
		q.hsell   = d[105];
		q.hqty    = d[136:106];
		q.hprice  = d[168:137];
		return q;
	endfunction

	function automatic queue_resp_t apply_order(order_req_t r);
		queue_resp_t q;
		int slot;
		q = '{default: '0};
		q.status = StOk;
		case (r.req)
			ReqPush: begin
				if (book.size() >= Cap) begin
					q.status = StFull;
				end else begin
					slot = 0;
					while (slot < book.size() && book[slot].stamp >= r.stamp) slot++;
					book.insert(slot, r);
				end
			end
			ReqPop: begin
				if (book.size() == 0) q.status = StEmpty;
				else void'(book.pop_front());
			end
			ReqFind: begin
				q.status = StNotFound;
				foreach (book[i]) begin
					if (book[i].stamp == r.stamp && book[i].oid == r.oid) begin
						q.status = StOk;
						q.found = 6'(i);
						break;
					end
				end
			end
			default: begin
				if (r.pos >= book.size()) q.status = StBadIndex;
				else book.delete(r.pos);
			end
		endcase
		q.count = 7'(book.size());
		if (book.size() > 0) begin
			q.hvalid  = 1'b1;
			q.hstamp  = book[0].stamp;
			q.hoid    = book[0].oid;
			q.htrader = book[0].trader;
			q.hkind   = book[0].kind;
			q.hbuy    = book[0].buy;
			q.hsell   = book[0].sell;
			q.hqty    = book[0].qty;
			q.hprice  = book[0].price;
		end
		return q;
	endfunction

	function automatic order_req_t rand_order(logic [1:0] req);
		order_req_t r;
		r.req    = req;
		r.stamp  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40);
		r.oid    = 31'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7));
		r.trader = 16'($urandom);
		r.kind   = 8'($urandom);
		r.buy    = 1'($urandom);
		r.sell   = 1'($urandom);
		r.qty    = 31'($urandom);
		r.price  = $urandom;
		r.pos    = 6'($urandom);
		if (req == ReqFind && book.size() > 0 && $urandom_range(0, 2) != 0) begin
			int k;
			k = $urandom_range(0, book.size() - 1);
			r.stamp = book[k].stamp;
			r.oid   = book[k].oid;
		end
		if (req == ReqErase && book.size() > 0 && $urandom_range(0, 3) != 0)
			r.pos = 6'($urandom_range(0, book.size() - 1));
		return r;
	endfunction

	task automatic send_order(order_req_t r, bit has_exp, queue_resp_t exp);
		queue_resp_t q;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 15)) @(negedge clk);
		s_tdata  <= pack_req(r);
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		q = apply_order(r);
		if (r.req == ReqFind && q.status == StOk) finds_hit++;
		if (q.status == StFull) fulls++;
		pending_resp.insert(pending_resp.size(), q);
		typed_flag.insert(typed_flag.size(), has_exp);
		typed_resp.insert(typed_resp.size(), exp);
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic compare_field(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			errors++;
			$display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
		end
	endtask

	initial begin
		int gap;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				gap = $urandom_range(1, 15);
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		queue_resp_t a, e, t;
		bit tf;
		if (arst_n && m_tvalid && m_tready) begin
			a = unpack_resp(m_tdata);
			resp_seen++;
			if (pending_resp.size() == 0) begin
				errors++;
				$display("%0t unexpected result %0h", $time, m_tdata);
			end else begin
				e  = pending_resp.pop_front();
				tf = typed_flag.pop_front();
				t  = typed_resp.pop_front();
				if (tf && t !== e) begin
					errors++;
					$display("%0t table row disagrees with predictor: expected %0h actual %0h",
						$time, t, e);
				end
				compare_field("status", 32'(e.status), 32'(a.status));
				compare_field("found_index", 32'(e.found), 32'(a.found));
				compare_field("entry_count", 32'(e.count), 32'(a.count));
				compare_field("head_valid", 32'(e.hvalid), 32'(a.hvalid));
				compare_field("head_stamp", e.hstamp, a.hstamp);
				compare_field("head_order_id", 32'(e.hoid), 32'(a.hoid));
				compare_field("head_trader", 32'(e.htrader), 32'(a.htrader));
				compare_field("head_kind", 32'(e.hkind), 32'(a.hkind));
				compare_field("head_buy", 32'(e.hbuy), 32'(a.hbuy));
				compare_field("head_sell", 32'(e.hsell), 32'(a.hsell));
				compare_field("head_quantity", 32'(e.hqty), 32'(a.hqty));
				compare_field("head_price", e.hprice, a.hprice);
			end
		end
	end

	function automatic order_req_t mk(logic [1:0] req, logic [31:0] st, logic [30:0] id,
			logic [5:0] pos);
		order_req_t r;
		r = '{req: req, stamp: st, oid: id, trader: 16'hFFFF, kind: 8'hFF, buy: 1'b1,
			sell: 1'b1, qty: 31'h7FFFFFFF, price: 32'hFFFFFFFF, pos: pos};
		return r;
	endfunction

	function automatic queue_resp_t empty_resp(logic [2:0] st);
		queue_resp_t q;
		q = '{default: '0};
		q.status = st;
		return q;
	endfunction

	initial begin
		dir_row_t rows[$];
		dir_row_t row;
		order_req_t r, z;
		queue_resp_t none;
		int n, wait_cnt;
		logic [1:0] op;

		errors = 0; resp_seen = 0; finds_hit = 0; fulls = 0; quiet = 0;
		arst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0;
		none = '{default: '0};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		z = '{default: '0};
		row = '{r: mk(ReqPop, '0, '0, '0), has_exp: 1'b1, exp: empty_resp(StEmpty)};
		rows.insert(rows.size(), row);
		row = '{r: mk(ReqFind, '0, '0, '0), has_exp: 1'b1, exp: empty_resp(StNotFound)};
		rows.insert(rows.size(), row);
		row = '{r: mk(ReqErase, '0, '0, '0), has_exp: 1'b1, exp: empty_resp(StBadIndex)};
		rows.insert(rows.size(), row);
		row = '{r: mk(ReqErase, '0, '0, 6'd63), has_exp: 1'b1, exp: empty_resp(StBadIndex)};
		rows.insert(rows.size(), row);
		row.has_exp = 1'b0; row.exp = none;
		row.r = z; rows.insert(rows.size(), row);
		row.r = mk(ReqPush, 32'hFFFFFFFF, 31'h7FFFFFFF, '0); rows.insert(rows.size(), row);
		row.r = mk(ReqPush, 32'd5, 31'd1, '0); row.r.buy = 1'b0;
		rows.insert(rows.size(), row);
		row.r = mk(ReqPush, 32'd5, 31'd2, '0); row.r.sell = 1'b0;
		rows.insert(rows.size(), row);
		row.r = mk(ReqFind, 32'd5, 31'd2, '0); rows.insert(rows.size(), row);
		row.r = mk(ReqFind, 32'd5, 31'd3, '0); rows.insert(rows.size(), row);
		row.r = mk(ReqFind, '0, '0, '0); rows.insert(rows.size(), row);
		row.r = mk(ReqErase, '0, '0, 6'd2); rows.insert(rows.size(), row);
		row.r = mk(ReqErase, '0, '0, 6'd3); rows.insert(rows.size(), row);
		row.r = mk(ReqPop, '0, '0, '0); rows.insert(rows.size(), row);
		row.r = mk(ReqErase, '0, '0, 6'd1); rows.insert(rows.size(), row);
		row.r = mk(ReqErase, '0, '0, '0); rows.insert(rows.size(), row);
		row.r = mk(ReqPop, '0, '0, '0); rows.insert(rows.size(), row);
		foreach (rows[i]) send_order(rows[i].r, rows[i].has_exp, rows[i].exp);

		for (n = 0; n < 850; n++) begin
			if (n > 760) quiet = 1;
			if (n >= 200 && n < 320) op = ($urandom_range(0, 5) == 0) ? ReqFind : ReqPush;
			else if (n >= 320 && n < 420) op = ($urandom_range(0, 2) == 0) ? ReqFind : ReqPop;
			else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: op = ReqPush;
					4, 5:       op = ReqFind;
					6, 7:       op = ReqErase;
					default:    op = ReqPop;
				endcase
			end
			r = rand_order(op);
			send_order(r, 1'b0, none);
		end

		wait_cnt = 0;
		while (pending_resp.size() > 0 && wait_cnt < 200000) begin
			@(posedge clk);
			wait_cnt++;
		end
		if (pending_resp.size() > 0) begin
			errors++;
			$display("%0t %0d results never arrived", $time, pending_resp.size());
		end
		repeat (200) @(posedge clk);
		$display("covered %0d requests, %0d results, %0d find hits, %0d full pushes",
			rows.size() + 850, resp_seen, finds_hit, fulls);
		if (errors == 0)
			$display("sorted_order_priority_queue_core regression: pass");
		else
			$display("sorted_order_priority_queue_core regression: fail");
		$finish;
	end
endmodule
